/* rtl/gmes_pkg.sv */
// shared types, constants and register defaults of the gamma + met event selector
`timescale 1ns / 1ps

package gmes_pkg;

  // event limits
  localparam int unsigned MAX_OBJECTS      = 64;
  localparam int unsigned CNT_W            = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned MAX_JETS_ALLOWED = 1;
  localparam int unsigned NUM_CUTS         = 16;
  localparam int unsigned TRIGGER_BIT      = 19;

  // angle constants, 1/4096 rad
  localparam logic [15:0] PI_FX     = 16'd12868;
  localparam logic [15:0] TWO_PI_FX = 16'd25736;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MET_MIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHOTON_PT_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHOTON_ETA_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_ETA_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_ETA_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DPHI_MIN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LEPTON_PT_MIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_JET_PT_MIN     = 3'd7;

  // register reset values
  localparam logic [15:0] RST_MET_MIN        = 16'd2400;
  localparam logic [15:0] RST_PHOTON_PT_MIN  = 16'd3520;
  localparam logic [12:0] RST_PHOTON_ETA_MAX = 13'd2560;
  localparam logic [12:0] RST_GAP_ETA_LOW    = 13'd1479;
  localparam logic [12:0] RST_GAP_ETA_HIGH   = 13'd1597;
  localparam logic [13:0] RST_DPHI_MIN       = 14'd8192;
  localparam logic [15:0] RST_LEPTON_PT_MIN  = 16'd160;
  localparam logic [15:0] RST_JET_PT_MIN     = 16'd480;

  // request codes on the input word
  typedef enum logic [2:0] {
    REQ_HEADER   = 3'd0,
    REQ_PHOTON   = 3'd1,
    REQ_ELECTRON = 3'd2,
    REQ_MUON     = 3'd3,
    REQ_JET      = 3'd4,
    REQ_END      = 3'd5
  } req_type_e;

  // operations handed from front to back
  typedef enum logic [2:0] {
    OP_HEADER   = 3'd0,
    OP_PHOTON   = 3'd1,
    OP_ELECTRON = 3'd2,
    OP_MUON     = 3'd3,
    OP_JET      = 3'd4,
    OP_END      = 3'd5
  } op_e;

  // classified item
  typedef struct packed {
    op_e         op;
    logic        hit;      // photon qualifies, lepton vetoes or jet counts
    logic [2:0]  hdr_ok;   // met cut, trigger, vertex
    logic [6:0]  filt;     // filter bits 9 and 5..0
    logic [14:0] angle;    // met phi for header, photon phi for photon
    logic [15:0] pt;
  } op_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] met_min;
    logic [15:0] photon_pt_min;
    logic [12:0] photon_eta_max;
    logic [12:0] gap_eta_low;
    logic [12:0] gap_eta_high;
    logic [13:0] dphi_min;
    logic [15:0] lepton_pt_min;
    logic [15:0] jet_pt_min;
  } cfg_t;

  // result word
  typedef struct packed {
    logic        pass;
    logic [4:0]  cuts_passed;
    logic [5:0]  photon_index;
    logic [13:0] delta_phi;
    logic [6:0]  jet_count;
  } result_t;

  // queue status toward the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

/* rtl/gmes_in_if.sv */
// input channel interface: one event item per word
`timescale 1ns / 1ps

interface gmes_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic               pv_good;
  logic [63:0]        hlt_word;
  logic [15:0]        met_filters;
  logic [15:0]        met;
  logic signed [14:0] met_phi;
  logic [15:0]        obj_pt;
  logic signed [13:0] obj_eta;
  logic signed [14:0] obj_phi;
  logic [11:0]        obj_id_bits;
  logic               pho_ele_veto;

  modport source (
    output valid, req_type, pv_good, hlt_word, met_filters, met, met_phi,
           obj_pt, obj_eta, obj_phi, obj_id_bits, pho_ele_veto,
    input  ready
  );

  modport sink (
    input  valid, req_type, pv_good, hlt_word, met_filters, met, met_phi,
           obj_pt, obj_eta, obj_phi, obj_id_bits, pho_ele_veto,
    output ready
  );
endinterface

/* rtl/gmes_out_if.sv */
// output channel interface: one selection result per word
`timescale 1ns / 1ps

interface gmes_out_if;
  logic        valid;
  logic        ready;
  logic        pass;
  logic [4:0]  cuts_passed;
  logic [5:0]  photon_index;
  logic [13:0] delta_phi;
  logic [6:0]  jet_count;

  modport source (
    output valid, pass, cuts_passed, photon_index, delta_phi, jet_count,
    input  ready
  );

  modport sink (
    input  valid, pass, cuts_passed, photon_index, delta_phi, jet_count,
    output ready
  );
endinterface

/* rtl/gmes_front.sv */
// front end: accepts input words and classifies them against the thresholds
`timescale 1ns / 1ps

module gmes_front (
  gmes_in_if.sink            in_if,
  input  gmes_pkg::cfg_t     cfg_i,
  input  gmes_pkg::queue_stat_t qstat_i,
  output logic               push_o,
  output gmes_pkg::op_t      push_data_o
);
  import gmes_pkg::*;

  logic signed [14:0] eta_ext;
  logic [14:0]        eta_mag;
  logic [13:0]        aeta;
  logic [13:0]        eta_max;
  logic [13:0]        gap_lo;
  logic [13:0]        gap_hi;
  logic               pho_ok;
  logic               lep_pt_ok;
  logic               known;
  op_t                op;

  // take a word whenever the queue has room
  assign in_if.ready = !qstat_i.full;

  // absolute eta, 8192 still fits
  always_comb begin
    eta_ext = {in_if.obj_eta[13], in_if.obj_eta};
    eta_mag = eta_ext[14] ? 15'(-eta_ext) : 15'(eta_ext);
    aeta    = eta_mag[13:0];
    eta_max = {1'b0, cfg_i.photon_eta_max};
    gap_lo  = {1'b0, cfg_i.gap_eta_low};
    gap_hi  = {1'b0, cfg_i.gap_eta_high};
  end

  // photon quality, lepton pt threshold
  assign pho_ok = (in_if.obj_pt >= cfg_i.photon_pt_min) && (aeta <= eta_max) &&
                  !((aeta > gap_lo) && (aeta < gap_hi)) &&
                  in_if.obj_id_bits[3] && in_if.pho_ele_veto;
  assign lep_pt_ok = in_if.obj_pt >= cfg_i.lepton_pt_min;

  // classify by request type
  always_comb begin
    known     = 1'b1;
    op.op     = OP_END;
    op.hit    = 1'b0;
    op.hdr_ok = {in_if.met >= cfg_i.met_min, in_if.hlt_word[TRIGGER_BIT], in_if.pv_good};
    op.filt   = {in_if.met_filters[9], in_if.met_filters[5:0]};
    op.angle  = in_if.obj_phi;
    op.pt     = in_if.obj_pt;
    case (req_type_e'(in_if.req_type))
      REQ_HEADER: begin
        op.op    = OP_HEADER;
        op.angle = in_if.met_phi;
      end
      REQ_PHOTON: begin
        op.op  = OP_PHOTON;
        op.hit = pho_ok;
      end
      REQ_ELECTRON: begin
        op.op  = OP_ELECTRON;
        op.hit = lep_pt_ok && in_if.obj_id_bits[0];
      end
      REQ_MUON: begin
        op.op  = OP_MUON;
        op.hit = lep_pt_ok && in_if.obj_id_bits[3] && in_if.obj_id_bits[11];
      end
      REQ_JET: begin
        op.op  = OP_JET;
        op.hit = (in_if.obj_pt >= cfg_i.jet_pt_min) && in_if.obj_id_bits[1];
      end
      REQ_END: begin
        op.op = OP_END;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unused codes are taken and dropped
  assign push_o      = in_if.valid && in_if.ready && known;
  assign push_data_o = op;

endmodule

/* rtl/gmes_queue.sv */
// short queue of classified operations between front and back
`timescale 1ns / 1ps

module gmes_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  gmes_pkg::op_t         push_data_i,
  input  logic                  pop_i,
  output gmes_pkg::op_t         pop_data_o,
  output gmes_pkg::queue_stat_t stat_o
);
  import gmes_pkg::*;

  op_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign stat_o.full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign stat_o.empty = count_q == '0;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/gmes_back.sv */
// back end: event state, best photon, vetoes, jet count and result word
`timescale 1ns / 1ps

module gmes_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gmes_pkg::cfg_t        cfg_i,
  input  gmes_pkg::queue_stat_t qstat_i,
  input  gmes_pkg::op_t         op_i,
  output logic                  pop_o,
  gmes_out_if.source            out_if
);
  import gmes_pkg::*;

  // event state
  logic [2:0]       hdr_ok_q, hdr_ok_d;
  logic [6:0]       filt_q, filt_d;
  logic [14:0]      met_angle_q, met_angle_d;
  logic [CNT_W-1:0] photons_q, photons_d;
  logic [15:0]      best_pt_q, best_pt_d;
  logic [5:0]       best_idx_q, best_idx_d;
  logic [14:0]      best_phi_q, best_phi_d;
  logic             have_best_q, have_best_d;
  logic             ele_veto_q, ele_veto_d;
  logic             mu_veto_q, mu_veto_d;
  logic [CNT_W-1:0] jets_q, jets_d;

  // output register
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  logic signed [15:0] diff;
  logic [15:0]        mag;
  logic [15:0]        red;
  logic [15:0]        fold;
  logic [13:0]        dphi;
  logic [NUM_CUTS-1:0] cuts;
  logic [NUM_CUTS-1:0] run;
  logic               out_free;

  // end words wait for a free output register, the rest go at once
  assign out_free = !out_valid_q || out_if.ready;
  assign pop_o    = !qstat_i.empty && ((op_i.op != OP_END) || out_free);

  // folded photon to met angle
  always_comb begin
    diff = {met_angle_q[14], met_angle_q} - {best_phi_q[14], best_phi_q};
    mag  = diff[15] ? 16'(-diff) : 16'(diff);
    red  = (mag >= TWO_PI_FX) ? mag - TWO_PI_FX : mag;
    fold = (red > PI_FX) ? TWO_PI_FX - red : red;
    dphi = have_best_q ? fold[13:0] : 14'd0;
  end

  // cuts in file order, counted up to the first failure
  always_comb begin
    cuts[0]    = hdr_ok_q[0];
    cuts[1]    = hdr_ok_q[1];
    cuts[2]    = photons_q != '0;
    cuts[3]    = hdr_ok_q[2];
    cuts[10:4] = ~filt_q;
    cuts[11]   = have_best_q;
    cuts[12]   = dphi >= cfg_i.dphi_min;
    cuts[13]   = !ele_veto_q;
    cuts[14]   = !mu_veto_q;
    cuts[15]   = jets_q <= CNT_W'(MAX_JETS_ALLOWED);
    run[0]     = cuts[0];
    for (int k = 1; k < NUM_CUTS; k++) begin
      run[k] = run[k-1] & cuts[k];
    end
  end

  // state update per operation
  always_comb begin
    hdr_ok_d    = hdr_ok_q;
    filt_d      = filt_q;
    met_angle_d = met_angle_q;
    photons_d   = photons_q;
    best_pt_d   = best_pt_q;
    best_idx_d  = best_idx_q;
    best_phi_d  = best_phi_q;
    have_best_d = have_best_q;
    ele_veto_d  = ele_veto_q;
    mu_veto_d   = mu_veto_q;
    jets_d      = jets_q;
    out_valid_d = out_valid_q && !out_if.ready;
    res_d       = res_q;
    if (pop_o) begin
      case (op_i.op)
        OP_HEADER, OP_END: begin
          hdr_ok_d    = '0;
          filt_d      = '0;
          met_angle_d = '0;
          photons_d   = '0;
          best_pt_d   = '0;
          best_idx_d  = '0;
          best_phi_d  = '0;
          have_best_d = 1'b0;
          ele_veto_d  = 1'b0;
          mu_veto_d   = 1'b0;
          jets_d      = '0;
          if (op_i.op == OP_HEADER) begin
            hdr_ok_d    = op_i.hdr_ok;
            filt_d      = op_i.filt;
            met_angle_d = op_i.angle;
          end else begin
            out_valid_d        = 1'b1;
            res_d.pass         = &run;
            res_d.cuts_passed  = 5'($countones(run));
            res_d.photon_index = have_best_q ? best_idx_q : 6'd0;
            res_d.delta_phi    = dphi;
            res_d.jet_count    = 7'(jets_q);
          end
        end
        OP_PHOTON: begin
          if (photons_q < CNT_W'(MAX_OBJECTS)) begin
            photons_d = photons_q + 1'b1;
            if (op_i.hit && (!have_best_q || (op_i.pt > best_pt_q))) begin
              have_best_d = 1'b1;
              best_pt_d   = op_i.pt;
              best_idx_d  = 6'(photons_q);
              best_phi_d  = op_i.angle;
            end
          end
        end
        OP_ELECTRON: begin
          if (op_i.hit) begin
            ele_veto_d = 1'b1;
          end
        end
        OP_MUON: begin
          if (op_i.hit) begin
            mu_veto_d = 1'b1;
          end
        end
        OP_JET: begin
          if (op_i.hit && (jets_q < CNT_W'(MAX_OBJECTS))) begin
            jets_d = jets_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_ok_q    <= '0;
      filt_q      <= '0;
      met_angle_q <= '0;
      photons_q   <= '0;
      best_pt_q   <= '0;
      best_idx_q  <= '0;
      best_phi_q  <= '0;
      have_best_q <= 1'b0;
      ele_veto_q  <= 1'b0;
      mu_veto_q   <= 1'b0;
      jets_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_ok_q    <= hdr_ok_d;
      filt_q      <= filt_d;
      met_angle_q <= met_angle_d;
      photons_q   <= photons_d;
      best_pt_q   <= best_pt_d;
      best_idx_q  <= best_idx_d;
      best_phi_q  <= best_phi_d;
      have_best_q <= have_best_d;
      ele_veto_q  <= ele_veto_d;
      mu_veto_q   <= mu_veto_d;
      jets_q      <= jets_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // output word
  assign out_if.valid        = out_valid_q;
  assign out_if.pass         = res_q.pass;
  assign out_if.cuts_passed  = res_q.cuts_passed;
  assign out_if.photon_index = res_q.photon_index;
  assign out_if.delta_phi    = res_q.delta_phi;
  assign out_if.jet_count    = res_q.jet_count;

endmodule

/* rtl/gamma_met_event_selector_top.sv */
// top level of the gamma + met event selector: config registers, front, queue, back
// throughput: one input word per cycle; the front stalls only when the queue is full
// an accepted word is written into the queue and is executed by the back once it reaches
//   the queue head; executing an end word loads its result into the output register
// the output register holds one result; further end words wait in the queue meanwhile
// reset: asynchronous, active low; thresholds return to defaults, event state and
//   queue are cleared, no result pending
`timescale 1ns / 1ps

module gamma_met_event_selector_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gmes_in_if.sink                           in_if,
  gmes_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [gmes_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gmes_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import gmes_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic        push;
  op_t         push_data;
  logic        pop;
  op_t         pop_data;
  queue_stat_t qstat;

  // configuration register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MET_MIN:        cfg_d.met_min        = cfg_wdata_i;
        CFG_PHOTON_PT_MIN:  cfg_d.photon_pt_min  = cfg_wdata_i;
        CFG_PHOTON_ETA_MAX: cfg_d.photon_eta_max = cfg_wdata_i[12:0];
        CFG_GAP_ETA_LOW:    cfg_d.gap_eta_low    = cfg_wdata_i[12:0];
        CFG_GAP_ETA_HIGH:   cfg_d.gap_eta_high   = cfg_wdata_i[12:0];
        CFG_DPHI_MIN:       cfg_d.dphi_min       = cfg_wdata_i[13:0];
        CFG_LEPTON_PT_MIN:  cfg_d.lepton_pt_min  = cfg_wdata_i;
        CFG_JET_PT_MIN:     cfg_d.jet_pt_min     = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.met_min        <= RST_MET_MIN;
      cfg_q.photon_pt_min  <= RST_PHOTON_PT_MIN;
      cfg_q.photon_eta_max <= RST_PHOTON_ETA_MAX;
      cfg_q.gap_eta_low    <= RST_GAP_ETA_LOW;
      cfg_q.gap_eta_high   <= RST_GAP_ETA_HIGH;
      cfg_q.dphi_min       <= RST_DPHI_MIN;
      cfg_q.lepton_pt_min  <= RST_LEPTON_PT_MIN;
      cfg_q.jet_pt_min     <= RST_JET_PT_MIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // classify incoming words
  gmes_front u_front (
    .in_if       (in_if),
    .cfg_i       (cfg_q),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  gmes_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (qstat)
  );

  // execute operations and produce results
  gmes_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .qstat_i (qstat),
    .op_i    (pop_data),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

/* rtl/gmes_checker.sv */
// port-level checker for the event selector, bound to the top level
`timescale 1ns / 1ps

module gmes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_pass_i,
  input logic [4:0]  out_cuts_passed_i,
  input logic [13:0] out_delta_phi_i
);
  import gmes_pkg::*;

  // a result offered and not taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // pass goes with all cuts passed
  a_pass_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_pass_i == (out_cuts_passed_i == 5'(NUM_CUTS))))
    else $error("pass does not match cut count");

  // cut count never exceeds the number of cuts
  a_cuts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_cuts_passed_i <= 5'(NUM_CUTS)))
    else $error("cut count out of range");

  // folded angle stays within pi
  a_dphi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({2'b00, out_delta_phi_i} <= PI_FX))
    else $error("delta phi beyond pi");

endmodule

bind gamma_met_event_selector_top gmes_checker u_gmes_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_pass_i        (out_if.pass),
  .out_cuts_passed_i (out_if.cuts_passed),
  .out_delta_phi_i   (out_if.delta_phi)
);
